// ----- rtl/core/sofd_pkg.sv -----
package sofd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'hA5;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 16'd1024;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd1;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_CMD    = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_PAYLD  = 3'd4,
    PH_CHK_HI = 3'd5,
    PH_CHK_LO = 3'd6
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_REJECT   = 2'd2,
    KIND_ABORT    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              resync;
  } in_beat_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  byte_index;
    logic [BYTE_W-1:0] frame_cmd;
    logic [LEN_W-1:0]  frame_length;
    logic [LEN_W-1:0]  frame_check;
  } out_beat_t;

  // Settings seen by the parser
  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [LEN_W-1:0]  max_payload;
  } cfg_t;

endpackage

// ----- rtl/core/sofd_in_stage.sv -----
module sofd_in_stage
  import sofd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_beat_t in_data,
  input  logic     advance,
  output logic     vld,
  output in_beat_t beat
);

  logic     vld_r;
  logic     vld_nxt;
  in_beat_t beat_r;
  logic     take;

  // Holding the beat stalls the source only when the parser cannot move it on.
  assign in_stall = vld_r & ~advance;
  assign take     = in_valid & ~in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      beat_r <= in_data;
    end
  end

  assign vld  = vld_r;
  assign beat = beat_r;

endmodule

// ----- rtl/core/sofd_parser.sv -----
module sofd_parser
  import sofd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,
  input  in_beat_t  beat,
  input  cfg_t      cfg,
  output logic      res_vld,
  output out_beat_t res
);

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] chk_hi_r, chk_hi_nxt;
  logic [LEN_W-1:0]  cnt_inc;
  logic [LEN_W-1:0]  len_full;
  phase_t            ph;

  assign cnt_inc  = cnt_r + LEN_W'(1);
  assign len_full = {len_r[LEN_W-1:BYTE_W], beat.rx_byte};

  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    chk_hi_nxt = chk_hi_r;
    res_vld    = 1'b0;
    res        = '0;
    ph         = phase_r;

    // lost bytes: abort any frame in flight, then parse this byte as hunting
    if (beat.resync) begin
      if (phase_r != PH_HUNT) begin
        res_vld          = 1'b1;
        res.kind         = KIND_ABORT;
        res.byte_index   = cnt_r;
        res.frame_cmd    = cmd_r;
        res.frame_length = len_r;
      end
      ph      = PH_HUNT;
      cnt_nxt = '0;
    end

    unique case (ph)
      PH_HUNT: begin
        if (beat.rx_byte == cfg.start_byte) begin
          cmd_nxt   = '0;
          len_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_CMD;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_CMD: begin
        cmd_nxt   = beat.rx_byte;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt   = {beat.rx_byte, {BYTE_W{1'b0}}};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt = len_full;
        cnt_nxt = '0;
        if (len_full > cfg.max_payload) begin
          res_vld          = 1'b1;
          res.kind         = KIND_REJECT;
          res.frame_cmd    = cmd_r;
          res.frame_length = len_full;
          phase_nxt        = PH_HUNT;
        end else if (len_full == '0) begin
          phase_nxt = PH_CHK_HI;
        end else begin
          phase_nxt = PH_PAYLD;
        end
      end
      PH_PAYLD: begin
        res_vld          = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.data_byte    = beat.rx_byte;
        res.byte_index   = cnt_r;
        res.frame_cmd    = cmd_r;
        res.frame_length = len_r;
        cnt_nxt          = cnt_inc;
        if (cnt_inc >= len_r) begin
          phase_nxt = PH_CHK_HI;
        end
      end
      PH_CHK_HI: begin
        chk_hi_nxt = beat.rx_byte;
        phase_nxt  = PH_CHK_LO;
      end
      PH_CHK_LO: begin
        res_vld          = 1'b1;
        res.kind         = KIND_COMPLETE;
        res.frame_cmd    = cmd_r;
        res.frame_length = len_r;
        res.frame_check  = {chk_hi_r, beat.rx_byte};
        phase_nxt        = PH_HUNT;
        cnt_nxt          = '0;
      end
      default: begin
        phase_nxt = PH_HUNT;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      cmd_r    <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      chk_hi_r <= '0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      cmd_r    <= cmd_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      chk_hi_r <= chk_hi_nxt;
    end
  end

endmodule

// ----- rtl/core/sofd_out_stage.sv -----
module sofd_out_stage
  import sofd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_beat_t res,
  output logic      free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic      vld_r;
  logic      vld_nxt;
  out_beat_t beat_r;

  // Register can take a new result when empty or when its beat leaves now.
  assign free = ~vld_r | ~out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = beat_r;

endmodule

// ----- rtl/core/sof_length_frame_deframer.sv -----
// Path: a byte accepted into the input stage register moves through the
// parser when the output register is free, and its result (if any) is
// loaded into that register, from which the result beat is offered.
// Throughput: one byte per cycle, set by the single parser state update; a
// stalled result register holds the parser and so stalls the input as well.
// Reset (rst_n low, synchronous): parser back to hunting, holds cleared,
// both stage registers empty, start byte 0xA5, max payload 1024.
module sof_length_frame_deframer
  import sofd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // received byte beats
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  // parse results
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic      ib_vld;
  in_beat_t  ib_beat;
  logic      advance;
  logic      res_vld;
  out_beat_t res;
  logic      out_free;

  logic [BYTE_W-1:0] start_byte_r;
  logic [LEN_W-1:0]  max_payload_r;
  cfg_t              cfg;

  // Config is always taken; the source must write only while no beat is in flight (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r  <= START_BYTE_RST;
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_BYTE:  start_byte_r  <= cfg_data[BYTE_W-1:0];
        CFG_MAX_PAYLOAD: max_payload_r <= cfg_data[LEN_W-1:0];
        default:         ;  // unknown index: write dropped
      endcase
    end
  end

  assign cfg.start_byte  = start_byte_r;
  assign cfg.max_payload = max_payload_r;

  // The held byte moves through the parser only when the result register
  // can take whatever it produces. Bytes with no result also wait for that.
  assign advance = ib_vld & out_free;

  sofd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .vld      (ib_vld),
    .beat     (ib_beat)
  );

  // Per-byte state machine: hunt, command, length, payload, check.
  sofd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .beat    (ib_beat),
    .cfg     (cfg),
    .res_vld (res_vld),
    .res     (res)
  );

  sofd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance & res_vld),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
